// ===== design/gasp_pkg.sv =====
//------------------------------------------------------------------------------
// gasp_pkg: shared types and constants for the grid A* path search
// Field widths, move costs, status codes, register indexes, neighbour order.
//------------------------------------------------------------------------------
`default_nettype none

package gasp_pkg;

	localparam int COORD_W  = 3;
	localparam int STATUS_W = 2;
	localparam int MAP_W_DEF = 8;
	localparam int MAP_H_DEF = 8;

	localparam logic [3:0] COST_ORTH = 4'd10;
	localparam logic [3:0] COST_DIAG = 4'd14;

	localparam logic [1:0] ST_TILE    = 2'd0;
	localparam logic [1:0] ST_AT_GOAL = 2'd1;
	localparam logic [1:0] ST_NO_PATH = 2'd2;

	localparam logic [1:0] REG_WALK   = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	// offset codes: 0 is -1, 1 is 0, 2 is +1; result is {dy, dx}
	function automatic logic [3:0] nb_off(input logic [2:0] dir);
		logic [3:0] r;
		begin
			case (dir)
				3'd0: r = {2'd0, 2'd0};
				3'd1: r = {2'd0, 2'd1};
				3'd2: r = {2'd0, 2'd2};
				3'd3: r = {2'd1, 2'd0};
				3'd4: r = {2'd1, 2'd2};
				3'd5: r = {2'd2, 2'd0};
				3'd6: r = {2'd2, 2'd1};
				3'd7: r = {2'd2, 2'd2};
				default: r = {2'd1, 2'd1};
			endcase
			return r;
		end
	endfunction

endpackage

`default_nettype wire

// ===== design/gasp_if.sv =====
//------------------------------------------------------------------------------
// gasp_req_if / gasp_rsp_if: request and result channels
// Valid/ready channels carrying the search request and one path result.
//------------------------------------------------------------------------------
`default_nettype none

interface gasp_req_if;
	logic valid;
	logic ready;
	logic [gasp_pkg::COORD_W-1:0] start_x;
	logic [gasp_pkg::COORD_W-1:0] start_y;
	logic [gasp_pkg::COORD_W-1:0] goal_x;
	logic [gasp_pkg::COORD_W-1:0] goal_y;
	modport source (output valid, start_x, start_y, goal_x, goal_y, input ready);
	modport sink (input valid, start_x, start_y, goal_x, goal_y, output ready);
endinterface

interface gasp_rsp_if;
	logic valid;
	logic ready;
	logic [gasp_pkg::COORD_W-1:0]  step_x;
	logic [gasp_pkg::COORD_W-1:0]  step_y;
	logic [gasp_pkg::STATUS_W-1:0] status;
	logic                          last;
	modport source (output valid, step_x, step_y, status, last, input ready);
	modport sink (input valid, step_x, step_y, status, last, output ready);
endinterface

`default_nettype wire

// ===== design/grid_astar_path_search.sv =====
//------------------------------------------------------------------------------
// grid_astar_path_search: A* search over an 8-neighbour tile grid
// Binary min-heap open list in on-chip memory, walked by one sequencer.
//------------------------------------------------------------------------------
//  channel | dir | handshake        | payload
//  req     | in  | valid/ready      | start_x, start_y, goal_x, goal_y
//  rsp     | out | valid/ready      | step_x, step_y, status, last
//  apb     | in  | psel/penable     | walkable_map @0, map_width @8, map_height @16
//
//  One request at a time: ready is high only while the sequencer is idle.
//  Each pop tests for an empty heap, reads the root and the last leaf,
//  sifts the leaf down (less work where only one child exists), visits
//  the neighbours, sifts new or cheaper tiles up (scanning the heap for
//  an open tile whose cost decreased) and checks for the goal; the
//  single-port heap and cost memories set the pace. Path tiles then go
//  out one at a time, each held by any stall on rsp.
//  Reset clears control state and tile marks, not memories; marks are
//  flop vectors cleared as each search starts, so no clearing pass is needed.
//  A stalled result holds in the output register until rsp.ready.
//------------------------------------------------------------------------------
`default_nettype none

module grid_astar_path_search #(
	parameter int MAP_W = gasp_pkg::MAP_W_DEF,
	parameter int MAP_H = gasp_pkg::MAP_H_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	gasp_req_if.sink    req,
	gasp_rsp_if.source  rsp,
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [4:0]  paddr,
	input  wire  [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);

	// sequencer states
	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_POP0  = 5'd1;
	localparam logic [4:0] S_POP1  = 5'd2;
	localparam logic [4:0] S_POP2  = 5'd3;
	localparam logic [4:0] S_SDF   = 5'd4;
	localparam logic [4:0] S_SD1   = 5'd5;
	localparam logic [4:0] S_SD2   = 5'd6;
	localparam logic [4:0] S_SD3   = 5'd7;
	localparam logic [4:0] S_SD4   = 5'd8;
	localparam logic [4:0] S_NB    = 5'd9;
	localparam logic [4:0] S_NBG   = 5'd10;
	localparam logic [4:0] S_SCAN  = 5'd11;
	localparam logic [4:0] S_SCANC = 5'd12;
	localparam logic [4:0] S_SU0   = 5'd13;
	localparam logic [4:0] S_SU1   = 5'd14;
	localparam logic [4:0] S_SU2   = 5'd15;
	localparam logic [4:0] S_CHK   = 5'd16;
	localparam logic [4:0] S_WK0   = 5'd17;
	localparam logic [4:0] S_WK1   = 5'd18;
	localparam logic [4:0] S_OUT   = 5'd19;

	localparam logic [3:0] W_MAX = 4'(MAP_W);
	localparam logic [3:0] H_MAX = 4'(MAP_H);

	// configuration registers
	logic [63:0] walk_q;
	logic [3:0]  mw_q, mh_q;

	// search state
	logic [4:0]  state_q;
	logic [3:0]  w_q, h_q;
	logic [5:0]  st_q, gt_q;
	logic [63:0] open_q, closed_q;
	logic [6:0]  cnt_q;
	logic [5:0]  top_q, cur_q, mv_q, t_q, c1_q, c2_q, pt_q, nxt_q;
	logic [10:0] fm_q, fc1_q, gn_q;
	logic [9:0]  gcur_q;
	logic [6:0]  u_q, p_q, i_q;
	logic [2:0]  dir_q;
	logic        ae_q;
	logic [5:0]  k_q;

	// result register
	logic        ov_q;
	logic [2:0]  ox_q, oy_q;
	logic [1:0]  os_q;
	logic        ol_q;

	// memories: tiles are addressed as {y, x}
	logic [9:0]  g_mem [64];
	logic [10:0] f_mem [64];
	logic [5:0]  p_mem [64];
	logic [5:0]  h_mem [64];
	logic [9:0]  g_rd;
	logic [10:0] f_rd;
	logic [5:0]  p_rd, h_rd;

	logic        g_we, f_we, p_we, h_we;
	logic [5:0]  g_wa, f_wa, p_wa, h_wa, g_ra, f_ra, p_ra, h_ra;
	logic [9:0]  g_wd;
	logic [10:0] f_wd;
	logic [5:0]  p_wd, h_wd;

	//--------------------------------------------------------------------------
	// configuration port
	//--------------------------------------------------------------------------
	logic cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '0;
			mw_q   <= 4'd8;
			mh_q   <= 4'd8;
		end else if (cfg_wr) begin
			case (paddr[4:3])
				gasp_pkg::REG_WALK:   walk_q <= pwdata;
				gasp_pkg::REG_WIDTH:  mw_q   <= pwdata[3:0];
				gasp_pkg::REG_HEIGHT: mh_q   <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:3])
			gasp_pkg::REG_WALK:   prdata = walk_q;
			gasp_pkg::REG_WIDTH:  prdata = {60'd0, mw_q};
			gasp_pkg::REG_HEIGHT: prdata = {60'd0, mh_q};
			default:              prdata = '0;
		endcase
	end

	//--------------------------------------------------------------------------
	// request decode: clamp the map size, check for trivial requests
	//--------------------------------------------------------------------------
	logic [3:0] w_eff, h_eff;
	logic       req_fire, req_off, req_same, req_go;

	assign w_eff = (mw_q == 4'd0) ? 4'd1 : ((mw_q > W_MAX) ? W_MAX : mw_q);
	assign h_eff = (mh_q == 4'd0) ? 4'd1 : ((mh_q > H_MAX) ? H_MAX : mh_q);
	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign req_off   = ({1'b0, req.start_x} >= w_eff) || ({1'b0, req.start_y} >= h_eff) ||
	                   ({1'b0, req.goal_x} >= w_eff) || ({1'b0, req.goal_y} >= h_eff);
	assign req_same  = (req.start_x == req.goal_x) && (req.start_y == req.goal_y);
	assign req_go    = req_fire && !req_off && !req_same;

	//--------------------------------------------------------------------------
	// neighbour evaluation for the current direction
	//--------------------------------------------------------------------------
	logic [3:0]  nb_code, cx4, cy4;
	logic [5:0]  nb_t;
	logic [6:0]  nb_widx;
	logic        nb_in, nb_cand, nb_diag, nb_last;
	logic [2:0]  dxa, dya;
	logic [3:0]  hd;
	logic [7:0]  hc;
	logic [10:0] gnew, fnew;

	assign nb_code = gasp_pkg::nb_off(dir_q);
	assign cx4     = {1'b0, cur_q[2:0]} + {2'b00, nb_code[1:0]} - 4'd1;
	assign cy4     = {1'b0, cur_q[5:3]} + {2'b00, nb_code[3:2]} - 4'd1;
	assign nb_in   = (cx4 < w_q) && (cy4 < h_q);
	assign nb_t    = {cy4[2:0], cx4[2:0]};
	assign nb_widx = 7'(cy4[2:0]) * 7'(w_q) + 7'(cx4[2:0]);
	assign nb_cand = nb_in && !closed_q[nb_t] && walk_q[nb_widx[5:0]];
	assign nb_diag = (nb_code[1:0] != 2'd1) && (nb_code[3:2] != 2'd1);
	assign nb_last = (dir_q == 3'd7);
	assign dxa     = (cx4[2:0] > gt_q[2:0]) ? cx4[2:0] - gt_q[2:0] : gt_q[2:0] - cx4[2:0];
	assign dya     = (cy4[2:0] > gt_q[5:3]) ? cy4[2:0] - gt_q[5:3] : gt_q[5:3] - cy4[2:0];
	assign hd      = {1'b0, dxa} + {1'b0, dya};
	assign hc      = {1'b0, hd, 3'b000} + {3'b000, hd, 1'b0};
	assign gnew    = {1'b0, gcur_q} +
	                 {7'd0, (nb_diag ? gasp_pkg::COST_DIAG : gasp_pkg::COST_ORTH)};
	assign fnew    = gnew + {3'd0, hc};

	//--------------------------------------------------------------------------
	// sift-down child choice: ties go to the child
	//--------------------------------------------------------------------------
	logic [7:0]  u2;
	logic        has_c2, sd_b1;
	logic [10:0] sd_fb;
	logic [1:0]  sd_sel;

	assign u2     = {u_q, 1'b0};
	assign has_c2 = (u2 + 8'd1) <= {1'b0, cnt_q};
	assign sd_b1  = (fm_q >= fc1_q);
	assign sd_fb  = sd_b1 ? fc1_q : fm_q;

	always_comb begin
		sd_sel = 2'd0;
		if (state_q == S_SD3) begin
			sd_sel = (fm_q >= f_rd) ? 2'd1 : 2'd0;
		end else if (state_q == S_SD4) begin
			if (sd_fb >= f_rd) begin
				sd_sel = 2'd2;
			end else if (sd_b1) begin
				sd_sel = 2'd1;
			end
		end
	end

	logic su_swap;
	assign su_swap = (fm_q < f_rd) || (ae_q && (fm_q == f_rd));

	//--------------------------------------------------------------------------
	// memory port control
	//--------------------------------------------------------------------------
	always_comb begin
		g_we = 1'b0; g_wa = t_q; g_wd = gn_q[9:0]; g_ra = t_q;
		f_we = 1'b0; f_wa = t_q; f_wd = fm_q;      f_ra = h_rd;
		p_we = 1'b0; p_wa = t_q; p_wd = cur_q;     p_ra = cur_q;
		h_we = 1'b0; h_wa = '0;  h_wd = t_q;       h_ra = '0;
		case (state_q)
			S_IDLE: begin
				if (req_go) begin
					g_we = 1'b1; g_wa = {req.start_y, req.start_x}; g_wd = '0;
					f_we = 1'b1; f_wa = {req.start_y, req.start_x}; f_wd = '0;
					h_we = 1'b1; h_wa = '0; h_wd = {req.start_y, req.start_x};
				end
			end
			S_POP1: h_ra = 6'(cnt_q - 7'd1);
			S_POP2: begin
				f_ra = h_rd;
				g_ra = top_q;
			end
			S_SD1: begin
				if (u2 > {1'b0, cnt_q}) begin
					h_we = 1'b1; h_wa = 6'(u_q - 7'd1); h_wd = mv_q;
				end else begin
					h_ra = 6'(u2 - 8'd1);
				end
			end
			S_SD2: begin
				f_ra = h_rd;
				h_ra = u2[5:0];
			end
			S_SD3: begin
				f_ra = h_rd;
				if (!has_c2) begin
					h_we = 1'b1; h_wa = 6'(u_q - 7'd1);
					h_wd = (sd_sel == 2'd1) ? c1_q : mv_q;
				end
			end
			S_SD4: begin
				h_we = 1'b1; h_wa = 6'(u_q - 7'd1);
				case (sd_sel)
					2'd1:    h_wd = c1_q;
					2'd2:    h_wd = c2_q;
					default: h_wd = mv_q;
				endcase
			end
			S_NB: begin
				g_ra = nb_t;
				if (nb_cand && !open_q[nb_t] && (cnt_q < 7'd64)) begin
					g_we = 1'b1; g_wa = nb_t; g_wd = gnew[9:0];
					f_we = 1'b1; f_wa = nb_t; f_wd = fnew;
					p_we = 1'b1; p_wa = nb_t; p_wd = cur_q;
				end
			end
			S_NBG: begin
				if (gn_q < {1'b0, g_rd}) begin
					p_we = 1'b1;
					g_we = 1'b1;
				end
			end
			S_SCAN: h_ra = 6'(i_q - 7'd1);
			S_SCANC: begin
				if (h_rd == t_q) begin
					f_we = 1'b1;
				end
			end
			S_SU0: begin
				if (p_q == 7'd1) begin
					h_we = 1'b1; h_wa = '0; h_wd = t_q;
				end else begin
					h_ra = 6'((p_q >> 1) - 7'd1);
				end
			end
			S_SU1: f_ra = h_rd;
			S_SU2: begin
				h_we = 1'b1; h_wa = 6'(p_q - 7'd1);
				h_wd = su_swap ? pt_q : t_q;
			end
			S_WK0: p_ra = cur_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (g_we) g_mem[g_wa] <= g_wd;
		if (f_we) f_mem[f_wa] <= f_wd;
		if (p_we) p_mem[p_wa] <= p_wd;
		if (h_we) h_mem[h_wa] <= h_wd;
		g_rd <= g_mem[g_ra];
		f_rd <= f_mem[f_ra];
		p_rd <= p_mem[p_ra];
		h_rd <= h_mem[h_ra];
	end

	//--------------------------------------------------------------------------
	// sequencer
	//--------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ov_q     <= 1'b0;
			open_q   <= '0;
			closed_q <= '0;
			cnt_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						w_q <= w_eff;
						h_q <= h_eff;
						st_q <= {req.start_y, req.start_x};
						gt_q <= {req.goal_y, req.goal_x};
						if (req_off || req_same) begin
							ov_q <= 1'b1;
							ox_q <= '0;
							oy_q <= '0;
							os_q <= req_off ? gasp_pkg::ST_NO_PATH : gasp_pkg::ST_AT_GOAL;
							ol_q <= 1'b1;
							state_q <= S_OUT;
						end else begin
							open_q   <= '0;
							closed_q <= '0;
							cnt_q    <= 7'd1;
							state_q  <= S_POP0;
						end
					end
				end
				// pop the minimum: read root, then last leaf
				S_POP0: begin
					if (cnt_q == 7'd0) begin
						ov_q <= 1'b1;
						ox_q <= '0;
						oy_q <= '0;
						os_q <= gasp_pkg::ST_NO_PATH;
						ol_q <= 1'b1;
						state_q <= S_OUT;
					end else begin
						state_q <= S_POP1;
					end
				end
				S_POP1: begin
					top_q   <= h_rd;
					state_q <= S_POP2;
				end
				S_POP2: begin
					mv_q  <= h_rd;
					cnt_q <= cnt_q - 7'd1;
					cur_q <= top_q;
					closed_q[top_q] <= 1'b1;
					open_q[top_q]   <= 1'b0;
					state_q <= S_SDF;
				end
				S_SDF: begin
					gcur_q  <= g_rd;
					fm_q    <= f_rd;
					u_q     <= 7'd1;
					state_q <= S_SD1;
				end
				// sift the moved leaf down from the root
				S_SD1: begin
					if (u2 > {1'b0, cnt_q}) begin
						dir_q   <= '0;
						state_q <= S_NB;
					end else begin
						state_q <= S_SD2;
					end
				end
				S_SD2: begin
					c1_q    <= h_rd;
					state_q <= S_SD3;
				end
				S_SD3: begin
					fc1_q <= f_rd;
					c2_q  <= h_rd;
					if (has_c2) begin
						state_q <= S_SD4;
					end else if (sd_sel == 2'd1) begin
						u_q     <= u2[6:0];
						state_q <= S_SD1;
					end else begin
						dir_q   <= '0;
						state_q <= S_NB;
					end
				end
				S_SD4: begin
					case (sd_sel)
						2'd1: begin
							u_q     <= u2[6:0];
							state_q <= S_SD1;
						end
						2'd2: begin
							u_q     <= u2[6:0] + 7'd1;
							state_q <= S_SD1;
						end
						default: begin
							dir_q   <= '0;
							state_q <= S_NB;
						end
					endcase
				end
				// one neighbour per visit
				S_NB: begin
					t_q  <= nb_t;
					gn_q <= gnew;
					fm_q <= fnew;
					if (nb_cand && !open_q[nb_t]) begin
						if (cnt_q < 7'd64) begin
							cnt_q  <= cnt_q + 7'd1;
							p_q    <= cnt_q + 7'd1;
							ae_q   <= 1'b1;
							open_q[nb_t] <= 1'b1;
							state_q <= S_SU0;
						end else begin
							dir_q   <= dir_q + 3'd1;
							state_q <= nb_last ? S_CHK : S_NB;
						end
					end else if (nb_cand) begin
						state_q <= S_NBG;
					end else begin
						dir_q   <= dir_q + 3'd1;
						state_q <= nb_last ? S_CHK : S_NB;
					end
				end
				// open tile: take the cheaper route and locate it in the heap
				S_NBG: begin
					if (gn_q < {1'b0, g_rd}) begin
						i_q     <= 7'd1;
						state_q <= S_SCAN;
					end else begin
						dir_q   <= dir_q + 3'd1;
						state_q <= nb_last ? S_CHK : S_NB;
					end
				end
				S_SCAN: state_q <= S_SCANC;
				S_SCANC: begin
					if (h_rd == t_q) begin
						p_q     <= i_q;
						ae_q    <= 1'b0;
						state_q <= S_SU0;
					end else if (i_q >= cnt_q) begin
						dir_q   <= dir_q + 3'd1;
						state_q <= nb_last ? S_CHK : S_NB;
					end else begin
						i_q     <= i_q + 7'd1;
						state_q <= S_SCAN;
					end
				end
				// sift up toward the root
				S_SU0: begin
					if (p_q == 7'd1) begin
						dir_q   <= dir_q + 3'd1;
						state_q <= nb_last ? S_CHK : S_NB;
					end else begin
						state_q <= S_SU1;
					end
				end
				S_SU1: begin
					pt_q    <= h_rd;
					state_q <= S_SU2;
				end
				S_SU2: begin
					if (su_swap) begin
						p_q     <= p_q >> 1;
						state_q <= S_SU0;
					end else begin
						dir_q   <= dir_q + 3'd1;
						state_q <= nb_last ? S_CHK : S_NB;
					end
				end
				S_CHK: begin
					if (open_q[gt_q]) begin
						cur_q   <= gt_q;
						k_q     <= '0;
						state_q <= S_WK0;
					end else begin
						state_q <= S_POP0;
					end
				end
				// walk parents from the goal back to the start
				S_WK0: state_q <= S_WK1;
				S_WK1: begin
					nxt_q <= p_rd;
					ov_q  <= 1'b1;
					ox_q  <= cur_q[2:0];
					oy_q  <= cur_q[5:3];
					os_q  <= gasp_pkg::ST_TILE;
					ol_q  <= (p_rd == st_q) || (k_q == 6'd62);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (rsp.ready) begin
						ov_q <= 1'b0;
						if (ol_q) begin
							state_q <= S_IDLE;
						end else begin
							cur_q   <= nxt_q;
							k_q     <= k_q + 6'd1;
							state_q <= S_WK0;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid  = ov_q;
	assign rsp.step_x = ox_q;
	assign rsp.step_y = oy_q;
	assign rsp.status = os_q;
	assign rsp.last   = ol_q;

endmodule

`default_nettype wire

// ===== tb/grid_astar_path_search_tb.sv =====
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// grid_astar_path_search_tb: self-checking bench for the grid A* path search
// Drives search requests through a gapped valid/ready source. A built-in A*
// predictor mirrors the heap ordering and tie rules, and every returned path
// tile is checked in order. The APB port moves the map between phases.
//------------------------------------------------------------------------------
`default_nettype none

module grid_astar_path_search_tb;

	localparam int WDOG_LIMIT = 400000;
	localparam int LONG_HOLD  = 3000;

	typedef struct packed {
		logic [gasp_pkg::COORD_W-1:0] sx;
		logic [gasp_pkg::COORD_W-1:0] sy;
		logic [gasp_pkg::COORD_W-1:0] gx;
		logic [gasp_pkg::COORD_W-1:0] gy;
	} search_t;

	typedef struct packed {
		logic [gasp_pkg::COORD_W-1:0]  step_x;
		logic [gasp_pkg::COORD_W-1:0]  step_y;
		logic [gasp_pkg::STATUS_W-1:0] status;
		logic                          last;
	} step_t;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	gasp_req_if req_ch();
	gasp_rsp_if rsp_ch();

	grid_astar_path_search u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	search_t pending_q[$];
	step_t   path_q[$];
	int      err_cnt;

	// shadow of the register file, updated when a write lands
	logic [63:0] map_bits;
	logic [3:0]  map_cols_reg;
	logic [3:0]  map_rows_reg;

	// predictor state
	logic [1:0]  tmark[64];
	logic [9:0]  gval[64];
	logic [10:0] fval[64];
	logic [5:0]  from_tile[64];
	logic [5:0]  oheap[64];
	int          oheap_n;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	//--------------------------------------------------------------------------
	// Predictor: open-list heap helpers, positions are 1-based
	//--------------------------------------------------------------------------
	function automatic int f_at(int p);
		return fval[oheap[(p - 1) & 63]];
	endfunction

	function automatic void heap_swap(int a, int b);
		logic [5:0] t;
		t = oheap[(a - 1) & 63];
		oheap[(a - 1) & 63] = oheap[(b - 1) & 63];
		oheap[(b - 1) & 63] = t;
	endfunction

	// ties move up on insert, but only strict improvements after a decrease
	function automatic void bubble_up(int p, bit tie_moves);
		int a, b;
		while (p > 1) begin
			a = f_at(p);
			b = f_at(p / 2);
			if (a < b || (tie_moves && a == b)) begin
				heap_swap(p, p / 2);
				p = p / 2;
			end else
				break;
		end
	endfunction

	function automatic int take_cheapest();
		int top, n, u, v;
		top = oheap[0];
		oheap[0] = oheap[(oheap_n - 1) & 63];
		oheap_n--;
		n = oheap_n;
		v = 1;
		forever begin
			u = v;
			if (2 * u + 1 <= n) begin
				if (f_at(u) >= f_at(2 * u)) v = 2 * u;
				if (f_at(v) >= f_at(2 * u + 1)) v = 2 * u + 1;
			end else if (2 * u <= n) begin
				if (f_at(u) >= f_at(2 * u)) v = 2 * u;
			end
			if (u != v) heap_swap(u, v);
			else break;
		end
		return top;
	endfunction

	function automatic int clamp_size(logic [3:0] v);
		if (v == 0) return 1;
		if (v > 8) return 8;
		return v;
	endfunction

	function automatic int absdiff(int a, int b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic void push_flag(logic [1:0] st);
		step_t r;
		r = '{step_x: '0, step_y: '0, status: st, last: 1'b1};
		path_q = {path_q, r};
	endfunction

	// Run the search for one request and queue the path tiles, goal first.
	function automatic void plan_route(search_t s);
		int w, h, st, gt, cur, px, py, cx, cy, t, g, hc, k, cnt;
		bit found;
		step_t r;
		w = clamp_size(map_cols_reg);
		h = clamp_size(map_rows_reg);
		found = 1'b0;
		if (s.sx >= w || s.sy >= h || s.gx >= w || s.gy >= h) begin
			push_flag(gasp_pkg::ST_NO_PATH);
			return;
		end
		if (s.sx == s.gx && s.sy == s.gy) begin
			push_flag(gasp_pkg::ST_AT_GOAL);
			return;
		end
		foreach (tmark[i]) tmark[i] = 2'd0;
		st = (s.sy * w + s.sx) & 63;
		gt = (s.gy * w + s.gx) & 63;
		gval[st] = '0;
		fval[st] = '0;
		oheap[0] = st[5:0];
		oheap_n = 1;
		while (!found && oheap_n != 0) begin
			cur = take_cheapest() & 63;
			tmark[cur] = 2'd2;
			px = cur % w;
			py = cur / w;
			for (int dy = -1; dy <= 1; dy++) begin
				for (int dx = -1; dx <= 1; dx++) begin
					cx = px + dx;
					cy = py + dy;
					if (dx == 0 && dy == 0) continue;
					if (cx < 0 || cy < 0 || cx >= w || cy >= h) continue;
					t = (cy * w + cx) & 63;
					if (tmark[t] == 2'd2) continue;
					if (!map_bits[t]) continue;
					g = gval[cur] + ((dx != 0 && dy != 0) ?
						gasp_pkg::COST_DIAG : gasp_pkg::COST_ORTH);
					hc = (absdiff(cx, s.gx) + absdiff(cy, s.gy)) * gasp_pkg::COST_ORTH;
					if (tmark[t] != 2'd1) begin
						if (oheap_n >= 64) continue;
						gval[t] = g[9:0];
						fval[t] = 11'(g + hc);
						from_tile[t] = cur[5:0];
						oheap_n++;
						oheap[(oheap_n - 1) & 63] = t[5:0];
						bubble_up(oheap_n, 1'b1);
						tmark[t] = 2'd1;
					end else if (g < gval[t]) begin
						from_tile[t] = cur[5:0];
						gval[t] = g[9:0];
						for (int i = 1; i <= oheap_n; i++) begin
							if (oheap[(i - 1) & 63] == t) begin
								fval[t] = 11'(g + hc);
								bubble_up(i, 1'b0);
								break;
							end
						end
					end
				end
			end
			if (tmark[gt] == 2'd1) found = 1'b1;
		end
		if (!found) begin
			push_flag(gasp_pkg::ST_NO_PATH);
			return;
		end
		// walk parents back from the goal, start excluded
		cur = gt;
		cnt = 0;
		for (k = 0; k < 63 && cur != st; k++) begin
			r.step_x = 3'(cur % w);
			r.step_y = 3'(cur / w);
			r.status = gasp_pkg::ST_TILE;
			r.last   = 1'b0;
			path_q = {path_q, r};
			cnt++;
			cur = from_tile[cur];
		end
		if (cnt > 0) path_q[$].last = 1'b1;
	endfunction

	//--------------------------------------------------------------------------
	// Request driver: pop pending requests, idle for random gaps
	//--------------------------------------------------------------------------
	int      req_gap;
	search_t req_cur;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 10) return 0;
		if (r < 18) return $urandom_range(1, 4);
		return $urandom_range(20, 80);
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_gap = 0;
		end else begin
			// predict on acceptance, with the config in force right now
			if (req_ch.valid && req_ch.ready) plan_route(req_cur);
			if (!req_ch.valid || req_ch.ready) begin
				if (req_gap > 0) begin
					req_gap--;
					req_ch.valid <= 1'b0;
				end else if (pending_q.size() != 0) begin
					req_cur = pending_q.pop_front();
					req_ch.valid   <= 1'b1;
					req_ch.start_x <= req_cur.sx;
					req_ch.start_y <= req_cur.sy;
					req_ch.goal_x  <= req_cur.gx;
					req_ch.goal_y  <= req_cur.gy;
					req_gap = pick_gap();
				end else
					req_ch.valid <= 1'b0;
			end
		end
	end

	//--------------------------------------------------------------------------
	// Result monitor: check against the oldest expected tile, throttle ready
	//--------------------------------------------------------------------------
	int    rsp_hold;
	int    tiles_seen;
	bit    long_hold_done;
	step_t want;

	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			rsp_hold = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				tiles_seen++;
				if (path_q.size() == 0) begin
					$error("unexpected result: x=%0d y=%0d status=%0d last=%0d",
						rsp_ch.step_x, rsp_ch.step_y, rsp_ch.status, rsp_ch.last);
					err_cnt++;
				end else begin
					want = path_q.pop_front();
					if (rsp_ch.step_x !== want.step_x) begin
						$error("step_x: expected %0d, got %0d", want.step_x, rsp_ch.step_x);
						err_cnt++;
					end
					if (rsp_ch.step_y !== want.step_y) begin
						$error("step_y: expected %0d, got %0d", want.step_y, rsp_ch.step_y);
						err_cnt++;
					end
					if (rsp_ch.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, rsp_ch.status);
						err_cnt++;
					end
					if (rsp_ch.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, rsp_ch.last);
						err_cnt++;
					end
				end
			end
			// hold off once for a long stretch so that requests back up
			if (!long_hold_done && tiles_seen >= 40 && pending_q.size() >= 4) begin
				long_hold_done = 1'b1;
				rsp_hold = LONG_HOLD;
			end
			if (rsp_hold > 0) begin
				rsp_hold--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_hold = pick_gap();
				rsp_ch.ready <= (rsp_hold == 0);
			end
		end
	end

	//--------------------------------------------------------------------------
	// Watchdog: count cycles with no handshake of any kind
	//--------------------------------------------------------------------------
	int idle_cycles;

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || psel)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("[grid_astar_path_search] ERROR");
			$finish;
		end
	end

	//--------------------------------------------------------------------------
	// Stimulus
	//--------------------------------------------------------------------------
	task automatic reg_write(input logic [1:0] idx, input logic [63:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			gasp_pkg::REG_WALK:   map_bits     = val;
			gasp_pkg::REG_WIDTH:  map_cols_reg = val[3:0];
			gasp_pkg::REG_HEIGHT: map_rows_reg = val[3:0];
			default: ;
		endcase
	endtask

	task automatic add_search(input int sx, sy, gx, gy);
		search_t s;
		s = '{sx: 3'(sx), sy: 3'(sy), gx: 3'(gx), gy: 3'(gy)};
		pending_q = {pending_q, s};
	endtask

	// hold until every request is out and every tile is back
	task automatic drain();
		while (pending_q.size() != 0 || req_ch.valid || path_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// random sizes mostly 2 to 8, sometimes 0 to 15; bias coordinates onto the map
	task automatic random_phase(input int n_items);
		int w, h, r;
		logic [63:0] m;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			w = $urandom_range(0, 15);
			h = $urandom_range(0, 15);
		end else begin
			w = $urandom_range(2, 8);
			h = $urandom_range(2, 8);
		end
		m = {$urandom, $urandom} | {$urandom, $urandom};
		if ($urandom_range(0, 2) == 0) m = m | {$urandom, $urandom};
		reg_write(gasp_pkg::REG_WIDTH, 64'(w));
		reg_write(gasp_pkg::REG_HEIGHT, 64'(h));
		reg_write(gasp_pkg::REG_WALK, m);
		w = clamp_size(4'(w));
		h = clamp_size(4'(h));
		repeat (n_items) begin
			if ($urandom_range(0, 9) < 8)
				add_search($urandom_range(0, w - 1), $urandom_range(0, h - 1),
					$urandom_range(0, w - 1), $urandom_range(0, h - 1));
			else
				add_search($urandom_range(0, 7), $urandom_range(0, 7),
					$urandom_range(0, 7), $urandom_range(0, 7));
		end
		drain();
	endtask

	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		req_ch.valid   = 1'b0;
		req_ch.start_x = '0;
		req_ch.start_y = '0;
		req_ch.goal_x  = '0;
		req_ch.goal_y  = '0;
		rsp_ch.ready   = 1'b0;
		map_bits       = '0;
		map_cols_reg   = 4'd8;
		map_rows_reg   = 4'd8;
		err_cnt        = 0;
		tiles_seen     = 0;
		long_hold_done = 1'b0;
		idle_cycles    = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// reset map has no walkable tile: goal never opens
		add_search(0, 0, 7, 7);
		add_search(3, 3, 3, 3);
		drain();

		// open field, corners and neighbours
		reg_write(gasp_pkg::REG_WALK, '1);
		add_search(0, 0, 7, 7);
		add_search(7, 7, 0, 0);
		add_search(7, 0, 0, 7);
		add_search(0, 7, 7, 0);
		add_search(2, 2, 3, 3);
		add_search(4, 4, 5, 4);
		add_search(7, 7, 7, 7);
		drain();

		// wall with one gap, unwalkable start and unwalkable goal
		reg_write(gasp_pkg::REG_WALK, ~64'h0010_1010_1010_1010 & ~64'h1);
		add_search(0, 0, 7, 0);
		add_search(1, 4, 6, 4);
		add_search(6, 6, 4, 1);
		drain();

		// zero size acts as one tile; off-map coordinates
		reg_write(gasp_pkg::REG_WIDTH, 64'd0);
		reg_write(gasp_pkg::REG_HEIGHT, 64'd0);
		add_search(0, 0, 0, 0);
		add_search(1, 0, 0, 0);
		add_search(0, 0, 0, 5);
		drain();

		// oversized registers saturate to the full grid
		reg_write(gasp_pkg::REG_WIDTH, 64'd15);
		reg_write(gasp_pkg::REG_HEIGHT, 64'd15);
		reg_write(gasp_pkg::REG_WALK, '1);
		add_search(0, 7, 7, 0);
		add_search(7, 3, 0, 4);
		drain();

		// narrow strip
		reg_write(gasp_pkg::REG_WIDTH, 64'd3);
		reg_write(gasp_pkg::REG_HEIGHT, 64'd8);
		add_search(0, 0, 2, 7);
		add_search(2, 7, 0, 0);
		add_search(4, 0, 0, 0);
		drain();

		repeat (6) random_phase(21);

		drain();
		if (err_cnt == 0 && path_q.size() == 0)
			$display("[grid_astar_path_search] OK");
		else
			$display("[grid_astar_path_search] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
